[sv/pcap_stream_deframer_unit_macros.svh]
// Assertion macros used by the deframer parser.
`ifndef PCAP_STREAM_DEFRAMER_UNIT_MACROS_SVH
`define PCAP_STREAM_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define PSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

[sv/psd_pkg.sv]
// Types, codes and byte-order helpers for the capture stream deframer.
package psd_pkg;

  localparam int unsigned PADDR_W = 3;

  // Register index is paddr[2]; only index 0 exists.
  localparam logic REG_MAX_CAPTURE_LENGTH = 1'b0;
  localparam logic [15:0] MAX_CAPTURE_LENGTH_RESET = 16'hFFFF;

  localparam logic [31:0] MAGIC_PLAIN   = 32'hA1B2C3D4;
  localparam logic [31:0] MAGIC_SWAPPED = 32'hD4C3B2A1;

  localparam int unsigned HDR_DEPTH = 24;
  localparam logic [4:0] FILE_HDR_LAST = 5'd23;
  localparam logic [4:0] REC_HDR_LAST  = 5'd15;
  localparam logic [4:0] REC_HDR_BYTES = 5'd16;

  localparam logic [2:0] KIND_FILE_HDR   = 3'd0;
  localparam logic [2:0] KIND_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] KIND_REC_HDR    = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD    = 3'd3;
  localparam logic [2:0] KIND_BOGUS_LEN  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } psd_byte_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] format_major;
    logic [15:0] format_minor;
    logic [31:0] snapshot_length;
    logic [31:0] link_type;
    logic [31:0] time_seconds;
    logic [31:0] time_micros;
    logic [31:0] included_length;
    logic [31:0] original_length;
    logic [7:0]  payload_byte;
    logic        last;
  } psd_result_t;

  // Handshake between the input register and the parser.
  typedef struct packed {
    logic valid;
    logic advance;
  } psd_stage_ctl_t;

  // Assemble a 32-bit field from four disk bytes, lowest address first.
  function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic swap);
    get32 = swap ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
  endfunction

  function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic swap);
    get16 = swap ? {b0, b1} : {b1, b0};
  endfunction

endpackage

[sv/psd_cfg_regs.sv]
// APB register file holding the capture length limit.
module psd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [15:0]                 max_capture_length
);
  import psd_pkg::*;

  logic hit;

  assign hit    = (paddr[2] == REG_MAX_CAPTURE_LENGTH);
  assign pready = 1'b1;
  assign prdata = hit ? {16'b0, max_capture_length} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_capture_length <= MAX_CAPTURE_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_capture_length <= pwdata[15:0];
    end
  end

endmodule

[sv/psd_input_stage.sv]
// Input register: holds one byte transaction until the parser takes it.
module psd_input_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  psd_pkg::psd_byte_t  byte_item,
  output logic                byte_stall,
  input  logic                advance,
  output psd_pkg::psd_stage_ctl_t ctl,
  output psd_pkg::psd_byte_t  s1_item
);
  import psd_pkg::*;

  logic s1_valid;

  // Stall only while the held byte cannot move on.
  assign byte_stall  = s1_valid && !advance;
  assign ctl.valid   = s1_valid;
  assign ctl.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

endmodule

[sv/psd_parser.sv]
// Parse state, header byte store, field decode and result register.
`include "pcap_stream_deframer_unit_macros.svh"

module psd_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s1_valid,
  input  psd_pkg::psd_byte_t      s1_item,
  output logic                    advance,
  input  logic [15:0]             max_capture_length,
  output logic                    result_valid,
  output psd_pkg::psd_result_t    result_item,
  input  logic                    result_stall
);
  import psd_pkg::*;

  typedef enum logic [2:0] {
    PH_FILE_HDR = 3'd0,
    PH_REC_HDR  = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_HALTED   = 3'd3,
    PH_IGNORE   = 3'd4
  } phase_t;

  phase_t      phase, phase_next, eff_phase;
  logic [4:0]  byte_count, count_next, eff_count;
  logic        swap_needed, swap_next, eff_swap;
  logic [15:0] payload_remaining, rem_next, eff_rem, rem_dec;
  logic [7:0]  header_bytes [HDR_DEPTH];
  logic [7:0]  hb [HDR_DEPTH];
  logic        hdr_wr;
  logic [31:0] magic, incl;
  logic        res_valid;
  psd_result_t res;

  assign advance = s1_valid && (!result_valid || !result_stall);

  always_comb begin
    // A start flag restarts the parser before this byte is used.
    eff_phase = s1_item.start_of_file ? PH_FILE_HDR : phase;
    eff_count = s1_item.start_of_file ? 5'd0 : byte_count;
    eff_swap  = s1_item.start_of_file ? 1'b0 : swap_needed;
    eff_rem   = s1_item.start_of_file ? 16'd0 : payload_remaining;

    hb = header_bytes;
    hb[eff_count] = s1_item.data_byte;

    phase_next = eff_phase;
    count_next = eff_count;
    swap_next  = eff_swap;
    rem_next   = eff_rem;
    hdr_wr     = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    magic      = get32(hb[0], hb[1], hb[2], hb[3], 1'b0);
    incl       = get32(hb[8], hb[9], hb[10], hb[11], eff_swap);
    rem_dec    = (eff_rem != 16'd0) ? eff_rem - 16'd1 : 16'd0;

    case (eff_phase)
      PH_FILE_HDR: begin
        hdr_wr = 1'b1;
        if (eff_count == FILE_HDR_LAST) begin
          count_next = 5'd0;
          res_valid  = 1'b1;
          swap_next  = (magic == MAGIC_SWAPPED);
          if (magic != MAGIC_SWAPPED && magic != MAGIC_PLAIN) begin
            res.kind   = KIND_BAD_MAGIC;
            phase_next = PH_IGNORE;
          end else begin
            res.kind            = KIND_FILE_HDR;
            res.format_major    = get16(hb[4], hb[5], swap_next);
            res.format_minor    = get16(hb[6], hb[7], swap_next);
            res.snapshot_length = get32(hb[16], hb[17], hb[18], hb[19], swap_next);
            res.link_type       = get32(hb[20], hb[21], hb[22], hb[23], swap_next);
            phase_next          = PH_REC_HDR;
          end
        end else begin
          count_next = eff_count + 5'd1;
        end
      end
      PH_REC_HDR: begin
        hdr_wr = 1'b1;
        if (eff_count == REC_HDR_LAST) begin
          count_next          = 5'd0;
          res_valid           = 1'b1;
          res.included_length = incl;
          if (incl > {16'b0, max_capture_length}) begin
            res.kind   = KIND_BOGUS_LEN;
            phase_next = PH_HALTED;
          end else begin
            res.kind            = KIND_REC_HDR;
            res.time_seconds    = get32(hb[0], hb[1], hb[2], hb[3], eff_swap);
            res.time_micros     = get32(hb[4], hb[5], hb[6], hb[7], eff_swap);
            res.original_length = get32(hb[12], hb[13], hb[14], hb[15], eff_swap);
            if (incl == 32'd0) begin
              res.last = 1'b1;
            end else begin
              rem_next   = incl[15:0];
              phase_next = PH_PAYLOAD;
            end
          end
        end else begin
          count_next = eff_count + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = s1_item.data_byte;
        rem_next         = rem_dec;
        if (rem_dec == 16'd0) begin
          res.last   = 1'b1;
          phase_next = PH_REC_HDR;
          count_next = 5'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance && hdr_wr) begin
      header_bytes[eff_count] <= s1_item.data_byte;
    end
    if (advance) begin
      result_item <= res;
    end
    if (rst) begin
      phase             <= PH_FILE_HDR;
      byte_count        <= 5'd0;
      swap_needed       <= 1'b0;
      payload_remaining <= 16'd0;
      result_valid      <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      byte_count        <= count_next;
      swap_needed       <= swap_next;
      payload_remaining <= rem_next;
      result_valid      <= res_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  `PSD_ASSERT_IMP(a_payload_nonzero, clk, rst, phase == PH_PAYLOAD, payload_remaining != 16'd0)
  `PSD_ASSERT_IMP(a_rec_count, clk, rst, phase == PH_REC_HDR, byte_count < REC_HDR_BYTES)
  `PSD_ASSERT_NXT(a_bad_magic_ignore, clk, rst, advance && res_valid && res.kind == KIND_BAD_MAGIC, phase == PH_IGNORE)

endmodule

[sv/pcap_stream_deframer_unit.sv]
// Top level of the capture file stream deframer.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  byte     | in        | byte_valid / byte_stall     | byte_item (psd_byte_t)
//  result   | out       | result_valid / result_stall | result_item (psd_result_t)
//  config   | in        | APB psel/penable/pwrite     | paddr, pwdata, prdata
//
// One byte transaction per cycle while result_stall is low; each taken byte goes
// into the input register, then is decoded into the result register.
// rst is synchronous: the parser restarts in file header collection, no result pending.
// A stalled result holds in the result register; one more byte waits in the input
// register, and byte_stall rises only when both are full.
// Bytes that give no result (header collection, halted or ignored streams) still pass
// through the same path.
module pcap_stream_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  input  psd_pkg::psd_byte_t          byte_item,
  output logic                        byte_stall,
  output logic                        result_valid,
  output psd_pkg::psd_result_t        result_item,
  input  logic                        result_stall,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import psd_pkg::*;

  logic            advance;
  psd_stage_ctl_t  ctl;
  psd_byte_t       s1_item;
  logic [15:0]     max_capture_length;

  // Length limit register; write only while the stream is idle.
  psd_cfg_regs u_cfg (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .max_capture_length (max_capture_length)
  );

  // Hold the incoming byte; release it when the parser advances.
  psd_input_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .byte_stall (byte_stall),
    .advance    (advance),
    .ctl        (ctl),
    .s1_item    (s1_item)
  );

  // Decode the held byte against the parse state and register the result.
  psd_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .s1_valid           (ctl.valid),
    .s1_item            (s1_item),
    .advance            (advance),
    .max_capture_length (max_capture_length),
    .result_valid       (result_valid),
    .result_item        (result_item),
    .result_stall       (result_stall)
  );

endmodule

[tb/sv/psd_scoreboard_pkg.sv]
// Scoreboard for the capture stream deframer: parse prediction and result checking.
package psd_scoreboard_pkg;
  import psd_pkg::*;

  typedef enum logic [2:0] {
    PARSE_FILE_HDR,
    PARSE_REC_HDR,
    PARSE_PAYLOAD,
    PARSE_HALTED,
    PARSE_IGNORE
  } parse_phase_t;

  class deframe_scoreboard_t;
    logic [15:0]  cap_limit;
    parse_phase_t phase;
    logic [4:0]   hdr_count;
    logic [7:0]   hdr_bytes [HDR_DEPTH];
    logic         swap_bytes;
    logic [15:0]  payload_left;
    psd_result_t  expected_reports [$];
    int           reports_seen;
    int           errors;

    function new();
      cap_limit    = MAX_CAPTURE_LENGTH_RESET;
      phase        = PARSE_FILE_HDR;
      hdr_count    = '0;
      swap_bytes   = 1'b0;
      payload_left = '0;
      reports_seen = 0;
      errors       = 0;
    endfunction

    function void set_limit(logic [15:0] limit);
      cap_limit = limit;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function logic [31:0] hdr_word(int at);
      logic [31:0] w;
      w = {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
      if (swap_bytes) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
      return w;
    endfunction

    function logic [15:0] hdr_half(int at);
      logic [15:0] h;
      h = {hdr_bytes[at+1], hdr_bytes[at]};
      if (swap_bytes) h = {h[7:0], h[15:8]};
      return h;
    endfunction

    // Advance the parse by one accepted byte; queue the report it causes, if any.
    function void parse_byte(psd_byte_t item);
      psd_result_t rep;
      logic [31:0] magic;
      logic [31:0] incl;
      bit          produced;
      rep      = '0;
      produced = 1'b0;
      if (item.start_of_file) begin
        phase        = PARSE_FILE_HDR;
        hdr_count    = '0;
        swap_bytes   = 1'b0;
        payload_left = '0;
      end
      case (phase)
        PARSE_FILE_HDR: begin
          if (hdr_count >= 5'(HDR_DEPTH)) hdr_count = '0;
          hdr_bytes[hdr_count] = item.data_byte;
          hdr_count++;
          if (hdr_count == 5'(HDR_DEPTH)) begin
            hdr_count  = '0;
            swap_bytes = 1'b0;
            magic      = hdr_word(0);
            swap_bytes = (magic == MAGIC_SWAPPED);
            produced   = 1'b1;
            if (magic == MAGIC_PLAIN || magic == MAGIC_SWAPPED) begin
              rep.kind            = KIND_FILE_HDR;
              rep.format_major    = hdr_half(4);
              rep.format_minor    = hdr_half(6);
              rep.snapshot_length = hdr_word(16);
              rep.link_type       = hdr_word(20);
              phase               = PARSE_REC_HDR;
            end else begin
              rep.kind = KIND_BAD_MAGIC;
              phase    = PARSE_IGNORE;
            end
          end
        end
        PARSE_REC_HDR: begin
          if (hdr_count >= REC_HDR_BYTES) hdr_count = '0;
          hdr_bytes[hdr_count] = item.data_byte;
          hdr_count++;
          if (hdr_count == REC_HDR_BYTES) begin
            hdr_count           = '0;
            incl                = hdr_word(8);
            rep.included_length = incl;
            produced            = 1'b1;
            if (incl > {16'h0, cap_limit}) begin
              rep.kind = KIND_BOGUS_LEN;
              phase    = PARSE_HALTED;
            end else begin
              rep.kind            = KIND_REC_HDR;
              rep.time_seconds    = hdr_word(0);
              rep.time_micros     = hdr_word(4);
              rep.original_length = hdr_word(12);
              if (incl == 32'd0) begin
                rep.last = 1'b1;
              end else begin
                payload_left = incl[15:0];
                phase        = PARSE_PAYLOAD;
              end
            end
          end
        end
        PARSE_PAYLOAD: begin
          rep.kind         = KIND_PAYLOAD;
          rep.payload_byte = item.data_byte;
          produced         = 1'b1;
          if (payload_left != 16'd0) payload_left--;
          if (payload_left == 16'd0) begin
            rep.last  = 1'b1;
            phase     = PARSE_REC_HDR;
            hdr_count = '0;
          end
        end
        default: ;
      endcase
      if (produced) expected_reports.push_back(rep);
    endfunction

    task report_mismatch(string msg);
      $display("%0t deframer mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("report %0d %s: got %0h, expected %0h",
                                  reports_seen, name, got, want));
    endtask

    task check_report(psd_result_t got);
      psd_result_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("report %0d with none expected (kind %0d)",
                                  reports_seen, got.kind));
      end else begin
        want = expected_reports.pop_front();
        compare_field("kind", got.kind, want.kind);
        compare_field("format_major", got.format_major, want.format_major);
        compare_field("format_minor", got.format_minor, want.format_minor);
        compare_field("snapshot_length", got.snapshot_length, want.snapshot_length);
        compare_field("link_type", got.link_type, want.link_type);
        compare_field("time_seconds", got.time_seconds, want.time_seconds);
        compare_field("time_micros", got.time_micros, want.time_micros);
        compare_field("included_length", got.included_length, want.included_length);
        compare_field("original_length", got.original_length, want.original_length);
        compare_field("payload_byte", got.payload_byte, want.payload_byte);
        compare_field("last", got.last, want.last);
      end
      reports_seen++;
    endtask
  endclass

endpackage

[tb/sv/tb_pcap_stream_deframer_unit.sv]
// Testbench for pcap_stream_deframer_unit: directed and random capture files checked against a parse predictor.
module tb_pcap_stream_deframer_unit;
  import psd_pkg::*;
  import psd_scoreboard_pkg::*;

  localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_MAX_CAPTURE_LENGTH, 2'b00};

  // Every input starts at a known value; rst is high from time zero.
  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                byte_valid   = 1'b0;
  psd_byte_t           byte_item    = '0;
  logic                byte_stall;
  logic                result_valid;
  psd_result_t         result_item;
  logic                result_stall = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;

  deframe_scoreboard_t sb;

  // Stream under construction, mirror of the length limit, idle rates.
  psd_byte_t           byte_plan [$];
  int                  formed_bytes;
  logic [15:0]         cap_limit = MAX_CAPTURE_LENGTH_RESET;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;

  pcap_stream_deframer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_item    (byte_item),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_item  (result_item),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random, at the current receiver rate.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Sample both channels at the edge: check the finished transaction first, then
  // feed the newly taken byte to the predictor (its report cannot appear this early).
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_report(result_item);
      if (byte_valid && !byte_stall) sb.parse_byte(byte_item);
    end
  end

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b, logic sof);
    psd_byte_t it;
    it.data_byte     = b;
    it.start_of_file = sof;
    byte_plan.push_back(it);
  endfunction

  // Lay a field down in file order: little-endian, or big-endian when swapped.
  function automatic void push_u32(logic [31:0] v, logic swapped);
    if (swapped) begin
      push_byte(v[31:24], 1'b0); push_byte(v[23:16], 1'b0);
      push_byte(v[15:8], 1'b0);  push_byte(v[7:0], 1'b0);
    end else begin
      push_byte(v[7:0], 1'b0);   push_byte(v[15:8], 1'b0);
      push_byte(v[23:16], 1'b0); push_byte(v[31:24], 1'b0);
    end
  endfunction

  function automatic void push_u16(logic [15:0] v, logic swapped);
    if (swapped) begin
      push_byte(v[15:8], 1'b0); push_byte(v[7:0], 1'b0);
    end else begin
      push_byte(v[7:0], 1'b0);  push_byte(v[15:8], 1'b0);
    end
  endfunction

  function automatic void push_random_bytes(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
  endfunction

  // Set or clear the start-of-file flag of the byte at a given plan position.
  function automatic void mark_start(int at, logic sof);
    byte_plan[at].start_of_file = sof;
  endfunction

  function automatic void push_file_header(logic sof, logic swapped, logic [15:0] vmaj,
                                           logic [15:0] vmin, logic [31:0] snap,
                                           logic [31:0] link);
    int at;
    at = byte_plan.size();
    push_u32(MAGIC_PLAIN, swapped);
    push_u16(vmaj, swapped);
    push_u16(vmin, swapped);
    push_u32($urandom, swapped);     // time zone, unused
    push_u32($urandom, swapped);     // timestamp accuracy, unused
    push_u32(snap, swapped);
    push_u32(link, swapped);
    mark_start(at, sof);
  endfunction

  function automatic void push_bad_header();
    logic [31:0] magic;
    int          at;
    at = byte_plan.size();
    do magic = $urandom; while (magic == MAGIC_PLAIN || magic == MAGIC_SWAPPED);
    push_u32(magic, 1'b0);
    push_random_bytes(20);
    mark_start(at, 1'b1);
  endfunction

  function automatic void push_record(logic swapped, logic [31:0] sec, logic [31:0] usec,
                                      logic [31:0] incl, logic [31:0] orig);
    push_u32(sec, swapped);
    push_u32(usec, swapped);
    push_u32(incl, swapped);
    push_u32(orig, swapped);
  endfunction

  // Mostly short legal lengths, with the limit capped at 40, zero and a few over-limit values.
  function automatic logic [31:0] pick_length();
    int unsigned roll;
    logic [31:0] lim;
    roll = $urandom_range(0, 99);
    lim  = ({16'h0, cap_limit} < 32'd40) ? {16'h0, cap_limit} : 32'd40;
    if (roll < 4)  return {16'h0, cap_limit} + 32'd1;
    if (roll < 8)  return $urandom | 32'h0001_0000;
    if (roll < 16) return lim;
    if (roll < 26) return 32'd0;
    return 32'($urandom_range(0, (lim < 32'd8) ? lim : 32'd8));
  endfunction

  // Mostly well-formed files with random content; the rest bad magic or cut-off headers.
  function automatic void add_random_file();
    int unsigned roll;
    int unsigned nrec;
    int          at;
    logic        swapped;
    logic [31:0] incl;
    roll = $urandom_range(0, 99);
    at   = byte_plan.size();
    if (roll < 80) begin
      swapped = 1'($urandom_range(0, 1));
      push_file_header(1'b1, swapped, 16'($urandom), 16'($urandom), $urandom, $urandom);
      nrec = $urandom_range(1, 2);
      for (int unsigned i = 0; i < nrec; i++) begin
        incl = pick_length();
        push_record(swapped, $urandom, $urandom, incl, $urandom);
        if (incl > {16'h0, cap_limit}) begin
          // parser halts; trailing bytes are dropped
          push_random_bytes($urandom_range(0, 3));
          break;
        end
        if ($urandom_range(0, 19) == 0) begin
          // cut the record short; the next file's start flag drops the rest
          push_random_bytes(incl / 2);
          break;
        end
        push_random_bytes(incl);
      end
      formed_bytes += byte_plan.size() - at;
    end else if (roll < 90) begin
      push_bad_header();
      push_random_bytes($urandom_range(0, 5));
    end else begin
      push_random_bytes($urandom_range(1, 23));
      mark_start(at, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one byte, idling first at the sender rate; hold it until taken.
  task automatic send_byte(psd_byte_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (byte_stall);
  endtask

  task automatic send_plan();
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
  endtask

  // Drop valid and hold until every report is in, then let silent bytes drain
  // through the two-stage path.
  task automatic wait_idle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read the limit register back and compare with the mirror.
  task automatic check_limit_readback();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[15:0] !== cap_limit)
      sb.report_mismatch($sformatf("max_capture_length readback: got %0h, expected %0h",
                                   got[15:0], cap_limit));
  endtask

  task automatic reconfigure(logic [15:0] v);
    wait_idle();
    apb_write(v);
    cap_limit = v;
    sb.set_limit(v);
    // leave the bus idle between the write and the read back
    @(posedge clk);
    check_limit_readback();
  endtask

  // One configuration and idling phase, run until enough well-formed bytes went in.
  task automatic run_phase(int unsigned s_idle, int unsigned r_idle, logic [15:0] limit);
    reconfigure(limit);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    formed_bytes  = 0;
    while (formed_bytes < 40) begin
      add_random_file();
      send_plan();
      // now and then hold the sender until the result side is empty
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_limit_readback();

    send_idle_pct = 28;
    recv_idle_pct = 72;

    // No start flag after reset: the parser collects a header anyway.
    push_file_header(1'b0, 1'b0, 16'h0002, 16'h0004, 32'hFFFF_FFFF, 32'h0);
    // Zero-length record, then a record with extreme payload bytes.
    push_record(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_record(1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 32'd3, 32'hFFFF_FFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    // Byte-swapped file.
    push_file_header(1'b1, 1'b1, 16'hFFFF, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    push_record(1'b1, 32'd1, 32'd999999, 32'd1, 32'd60);
    push_byte(8'hA5, 1'b0);
    // Bad magic, then bytes that must be dropped.
    push_bad_header();
    push_random_bytes(4);
    // Over-limit length halts the parser.
    push_file_header(1'b1, 1'b0, 16'd2, 16'd4, 32'd65535, 32'd1);
    push_record(1'b0, $urandom, $urandom, 32'hFFFF_FFFF, $urandom);
    push_random_bytes(3);
    // Start flag inside a header, then a full-size record cut by a new file.
    push_random_bytes(10);
    mark_start(byte_plan.size() - 10, 1'b1);
    push_file_header(1'b1, 1'b0, 16'd2, 16'd4, 32'd65535, 32'd1);
    push_record(1'b0, $urandom, $urandom, 32'd65535, 32'd65535);
    push_random_bytes(5);
    push_file_header(1'b1, 1'b1, 16'd2, 16'd4, 32'd65535, 32'd1);
    push_record(1'b1, $urandom, $urandom, 32'd2, 32'd2);
    push_random_bytes(2);
    send_plan();

    // Random part: receiver-heavy idling, sender-heavy idling, then none.
    run_phase(28, 72, 16'h0000);
    run_phase(72, 28, 16'($urandom_range(1, 40)));
    run_phase(0, 0, 16'hFFFF);

    wait_idle();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_pcap_stream_deframer_unit: done, clean");
    end else begin
      $display("tb_pcap_stream_deframer_unit: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tb_pcap_stream_deframer_unit: done, errors");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/psd_pkg.sv
sv/psd_cfg_regs.sv
sv/psd_input_stage.sv
sv/psd_parser.sv
sv/pcap_stream_deframer_unit.sv
tb/sv/psd_scoreboard_pkg.sv
tb/sv/tb_pcap_stream_deframer_unit.sv
